>>> design/nvg_pkg.sv
// ============================================================================
// nvg_pkg
// Shared types and constants for the note velocity gradient block.
// ============================================================================
package nvg_pkg;

   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int VALUE_W    = 16;
   localparam int INDEX_W    = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // Quotient magnitude stays below 2**16, so 16 quotient bits, 4 per stage.
   localparam int QUOT_W     = 16;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = QUOT_W / DIV_BITS;
   localparam int MAG_W      = QUOT_W + NOTE_W;

   // Capture, multiply, magnitude, divider, interpolate, mode, output.
   localparam int NUM_STAGES = DIV_STAGES + 6;

   localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

   typedef enum logic [1:0] {
      MODE_OFFSET   = 2'd0,
      MODE_MULTIPLY = 2'd1,
      MODE_FIXED    = 2'd2,
      MODE_INVALID  = 2'd3
   } mode_type;

   localparam logic [INDEX_W-1:0] REG_MODE        = 3'd0;
   localparam logic [INDEX_W-1:0] REG_NOTE_LOWER  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_NOTE_UPPER  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_VALUE_LOWER = 3'd3;
   localparam logic [INDEX_W-1:0] REG_VALUE_UPPER = 3'd4;

   typedef struct packed {
      logic             on;
      logic [VEL_W-1:0] vel;
      logic             sel_lo;
      logic             sel_hi;
      logic             neg;
   } ctl_type;

endpackage

>>> design/note_velocity_gradient.sv
// ============================================================================
// note_velocity_gradient
// Keyboard velocity gradient: maps the note across a value range and applies
// it to note-on velocities in offset, multiply or fixed mode.
// ============================================================================
// The request channel carries one MIDI event per beat: req_tuser is the
// note-on flag, req_tdata holds note and velocity. The response channel
// returns exactly one beat per request, in order, with the new velocity and
// a clip flag. The csr channel writes the mode, note range and Q8.8 value
// range; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. The datapath is a
// ten-stage pipeline: capture, gradient multiply, sign and magnitude, four
// long-division stages of four quotient bits each, interpolation, mode
// multiply, and truncation with saturation into the output register. One
// request is taken every cycle unless the receiver stalls a full pipeline.
// Each stage holds a valid bit and advances whenever the stage after it is
// empty or advancing, so a stalled receiver fills the empty stages first and
// req_tready falls only when all ten stages hold beats.
// Reset clears all valid bits and loads the register defaults: multiply mode,
// notes 0 to 127, both values 1.0.
// ============================================================================
module note_velocity_gradient (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [6:0] note, [13:7] velocity, [15:14] zero.
   input  logic [nvg_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] is_note_on.
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [6:0] new_velocity, [7] clipped.
   output logic [nvg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nvg_pkg::INDEX_W-1:0]   csr_index,
   input  logic [nvg_pkg::VALUE_W-1:0]   csr_wdata
);

   localparam int NS = nvg_pkg::NUM_STAGES;
   localparam int DS = nvg_pkg::DIV_STAGES;
   localparam int NW = nvg_pkg::NOTE_W;
   localparam int VW = nvg_pkg::VEL_W;
   localparam int QW = nvg_pkg::QUOT_W;
   localparam int MW = nvg_pkg::MAG_W;
   localparam int DB = nvg_pkg::DIV_BITS;

   nvg_pkg::mode_type             mode_ff;
   logic [NW-1:0]                 note_lower_ff;
   logic [NW-1:0]                 note_upper_ff;
   logic signed [15:0]            value_lower_ff;
   logic signed [15:0]            value_upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= nvg_pkg::MODE_MULTIPLY;
         note_lower_ff  <= 7'd0;
         note_upper_ff  <= 7'd127;
         value_lower_ff <= 16'sd256;
         value_upper_ff <= 16'sd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            nvg_pkg::REG_MODE:        mode_ff <= nvg_pkg::mode_type'(csr_wdata[1:0]);
            nvg_pkg::REG_NOTE_LOWER:  note_lower_ff <= csr_wdata[NW-1:0];
            nvg_pkg::REG_NOTE_UPPER:  note_upper_ff <= csr_wdata[NW-1:0];
            nvg_pkg::REG_VALUE_LOWER: value_lower_ff <= csr_wdata;
            nvg_pkg::REG_VALUE_UPPER: value_upper_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic [NW-1:0] dx;
   assign dx = note_upper_ff - note_lower_ff;

   // Valid bits and per-stage advance.
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = adv[0];

   // Control fields that ride along with the arithmetic.
   nvg_pkg::ctl_type ctl_ff [NS-1];
   nvg_pkg::ctl_type ctl_in [NS-1];

   logic [NW-1:0] req_note;
   logic [VW-1:0] req_vel;
   assign req_note = req_tdata[NW-1:0];
   assign req_vel  = req_tdata[NW+VW-1:NW];

   // Stage 0: capture, range flags, slope and note offset.
   logic signed [16:0] dy0_ff, dy0_in;
   logic [NW-1:0]      off0_ff, off0_in;

   always_comb begin
      dy0_in  = {value_upper_ff[15], value_upper_ff} - {value_lower_ff[15], value_lower_ff};
      off0_in = req_note - note_lower_ff;
   end

   // Stage 1: slope times offset.
   logic signed [24:0] prod1_ff, prod1_in;
   assign prod1_in = dy0_ff * $signed({1'b0, off0_ff});

   // Stage 2: sign and magnitude of the product.
   logic [24:0]   abs2;
   logic [MW-1:0] mag2_ff, mag2_in;
   assign abs2    = prod1_ff[24] ? 25'(-prod1_ff) : 25'(prod1_ff);
   assign mag2_in = abs2[MW-1:0];

   always_comb begin
      ctl_in[0].on     = req_tuser;
      ctl_in[0].vel    = req_vel;
      ctl_in[0].sel_lo = (req_note <= note_lower_ff);
      ctl_in[0].sel_hi = (req_note >= note_upper_ff);
      ctl_in[0].neg    = 1'b0;
      for (int k = 1; k < NS - 1; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[2].neg = prod1_ff[24];
   end

   // Stages 3 to 3+DS-1: restoring long division by the note span.
   logic [NW-1:0] rem_ff [DS];
   logic [QW-1:0] low_ff [DS];
   logic [QW-1:0] quo_ff [DS];
   logic [NW-1:0] rem_in [DS];
   logic [QW-1:0] low_in [DS];
   logic [QW-1:0] quo_in [DS];

   for (genvar d = 0; d < DS; d++) begin : g_div
      logic [NW-1:0] rem_src;
      logic [QW-1:0] low_src;
      logic [QW-1:0] quo_src;

      if (d == 0) begin : g_first
         assign rem_src = mag2_ff[MW-1:QW];
         assign low_src = mag2_ff[QW-1:0];
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[d-1];
         assign low_src = low_ff[d-1];
         assign quo_src = quo_ff[d-1];
      end

      always_comb begin
         logic [NW-1:0] r;
         logic [QW-1:0] lo;
         logic [QW-1:0] q;
         logic [NW:0]   t;
         r  = rem_src;
         lo = low_src;
         q  = quo_src;
         for (int b = 0; b < DB; b++) begin
            t  = {r, lo[QW-1]};
            lo = {lo[QW-2:0], 1'b0};
            if (t >= {1'b0, dx}) begin
               t = t - {1'b0, dx};
               q = {q[QW-2:0], 1'b1};
            end else begin
               q = {q[QW-2:0], 1'b0};
            end
            r = t[NW-1:0];
         end
         rem_in[d] = r;
         low_in[d] = lo;
         quo_in[d] = q;
      end

      always_ff @(posedge clock) begin
         if (adv[3+d]) begin
            rem_ff[d] <= rem_in[d];
            low_ff[d] <= low_in[d];
            quo_ff[d] <= quo_in[d];
         end
      end
   end

   // Interpolation stage: clamp or lower value plus signed quotient.
   localparam int SI = 3 + DS;
   logic signed [15:0] v_ff, v_in;
   logic [17:0]        qs;
   logic [17:0]        vsum;

   always_comb begin
      qs   = ctl_ff[SI-1].neg ? 18'(-{2'b0, quo_ff[DS-1]}) : {2'b0, quo_ff[DS-1]};
      vsum = {{2{value_lower_ff[15]}}, value_lower_ff} + qs;
      if (ctl_ff[SI-1].sel_lo) begin
         v_in = value_lower_ff;
      end else if (ctl_ff[SI-1].sel_hi) begin
         v_in = value_upper_ff;
      end else begin
         v_in = $signed(vsum[15:0]);
      end
   end

   // Mode stage: multiply by velocity or pass the value.
   localparam int SM = SI + 1;
   logic signed [23:0] x_ff, x_in;

   always_comb begin
      if (mode_ff == nvg_pkg::MODE_MULTIPLY) begin
         x_in = $signed({1'b0, ctl_ff[SM-1].vel}) * v_ff;
      end else begin
         x_in = {{8{v_ff[15]}}, v_ff};
      end
   end

   // Output stage: truncate toward zero, add, saturate.
   localparam int SO = SM + 1;
   nvg_pkg::ctl_type    oc;
   logic signed [23:0]  bias;
   logic signed [15:0]  tq;
   logic signed [17:0]  raw;
   logic [VW-1:0]       nvel_in, nvel_ff;
   logic                clip_in, clip_ff;

   always_comb begin
      oc   = ctl_ff[SO-1];
      bias = x_ff + (x_ff[23] ? 24'sd255 : 24'sd0);
      tq   = bias[23:8];
      if (mode_ff == nvg_pkg::MODE_OFFSET) begin
         raw = {{2{tq[15]}}, tq} + $signed({11'b0, oc.vel});
      end else begin
         raw = {{2{tq[15]}}, tq};
      end
      if (!oc.on) begin
         nvel_in = oc.vel;
         clip_in = 1'b0;
      end else if (oc.vel == '0 || mode_ff == nvg_pkg::MODE_INVALID) begin
         nvel_in = '0;
         clip_in = 1'b0;
      end else if (raw < 0) begin
         nvel_in = '0;
         clip_in = 1'b1;
      end else if (raw > $signed({11'b0, nvg_pkg::VEL_MAX})) begin
         nvel_in = nvg_pkg::VEL_MAX;
         clip_in = 1'b1;
      end else begin
         nvel_in = raw[VW-1:0];
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS - 1; k++) begin
         if (adv[k]) begin
            ctl_ff[k] <= ctl_in[k];
         end
      end
      if (adv[0]) begin
         dy0_ff  <= dy0_in;
         off0_ff <= off0_in;
      end
      if (adv[1]) begin
         prod1_ff <= prod1_in;
      end
      if (adv[2]) begin
         mag2_ff <= mag2_in;
      end
      if (adv[SI]) begin
         v_ff <= v_in;
      end
      if (adv[SM]) begin
         x_ff <= x_in;
      end
      if (adv[SO]) begin
         nvel_ff <= nvel_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {clip_ff, nvel_ff};

endmodule

>>> design/nvg_checker.sv
// ============================================================================
// nvg_checker
// Port-level checks for the note velocity gradient block, bound to the top.
// ============================================================================
module nvg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [nvg_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // After reset no beat is left in the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // A clipped result sits on one of the saturation bounds.
   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |->
         (rsp_tdata[6:0] == '0 || rsp_tdata[6:0] == nvg_pkg::VEL_MAX))
      else $error("clip flag set on an unsaturated velocity");

   // Requests are refused only when the output is held by the receiver.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without a stalled response");

endmodule

bind note_velocity_gradient nvg_checker u_nvg_checker (.*);
